@@ hw/rtl/rtu_mfe_pkg.sv @@
// Shared types and constants of the RTU master frame engine.
// Used by the front, queue, back and top modules; no dependencies.

package rtu_mfe_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 64;

  localparam logic [31:0] GAP_TICKS_RST  = 32'd215038;
  localparam logic [31:0] RESP_TICKS_RST = 32'd5898200;

  // link state codes
  localparam logic [2:0] LS_IDLE      = 3'd0;
  localparam logic [2:0] LS_SENDING   = 3'd1;
  localparam logic [2:0] LS_WAIT      = 3'd2;
  localparam logic [2:0] LS_RECEIVING = 3'd3;
  localparam logic [2:0] LS_RECEIVED  = 3'd4;
  localparam logic [2:0] LS_TIMEOUT   = 3'd5;

  // register index on the configuration port (paddr[2])
  localparam logic REG_GAP  = 1'b0;
  localparam logic REG_RESP = 1'b1;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_RX_BYTE = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_TX_DONE = 3'd3,
    CMD_FETCH   = 3'd4,
    CMD_RESET   = 3'd5
  } cmd_e;

  // one job from front to back
  typedef struct packed {
    logic [2:0] link_state;
    logic       accepted;
    logic [6:0] tx_length;
    logic       fetch;
  } job_t;

  localparam int unsigned JOB_W = $bits(job_t);

endpackage

@@ hw/rtl/rtu_master_frame_engine.sv @@
// Top level of the RTU master frame engine: configuration registers,
// front part, job queue and back part. Depends on rtu_mfe_pkg and submodules.
//
//  Port group   Dir  Payload
//  s_axis_*     in   tdata: command, rx_data, send_length
//  m_axis_*     out  tdata: link_state, accepted, tx_length, frame_byte,
//                    frame_length; tlast: last beat of the item
//  APB          in   gap_ticks at 0x0, respond_timeout_ticks at 0x4
//
// An input beat is taken each cycle while the two-entry job queue has room.
// Every item gives one result beat, except a fetch, which streams N bytes at
// one per cycle while the output is ready, from the frame buffer (one registered read port).
// Input stalls from an accepted fetch until its last buffer read is issued.
// Reset is asynchronous; the buffer is not cleared and needs no sweep.

module rtu_master_frame_engine
  import rtu_mfe_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [2:0] command, [10:3] rx_data, [26:11] send_length
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [2:0] link_state, [3] accepted, [10:4] tx_length,
                                     // [18:11] frame_byte, [25:19] frame_length
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic [31:0]   gap_q, gap_d;
  logic [31:0]   resp_q, resp_d;
  logic          cfg_wr;

  logic          q_full, q_valid, push, pop, fetch_done;
  job_t          push_job, pop_job;
  logic [CW-1:0] push_cnt, pop_cnt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_RESP) ? resp_q : gap_q;

  always_comb begin
    gap_d  = gap_q;
    resp_d = resp_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_GAP:  gap_d  = pwdata;
        REG_RESP: resp_d = pwdata;
        default:  gap_d  = gap_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q  <= GAP_TICKS_RST;
      resp_q <= RESP_TICKS_RST;
    end else begin
      gap_q  <= gap_d;
      resp_q <= resp_d;
    end
  end

  rtu_mfe_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tdata[2:0]),
    .rx_data_i   (s_axis_tdata[10:3]),
    .send_len_i  (s_axis_tdata[26:11]),
    .gap_ticks_i (gap_q),
    .resp_ticks_i(resp_q),
    .q_full_i    (q_full),
    .fetch_done_i(fetch_done),
    .push_o      (push),
    .job_o       (push_job),
    .job_cnt_o   (push_cnt),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  rtu_mfe_queue #(
    .W(JOB_W + CW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_cnt, push_job}),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_data_o ({pop_cnt, pop_job})
  );

  rtu_mfe_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .job_i       (pop_job),
    .job_cnt_i   (pop_cnt),
    .pop_o       (pop),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .fetch_done_o(fetch_done),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

@@ hw/rtl/rtu_mfe_front.sv @@
// Front part: accepts input beats, runs link state, timer and receive count,
// writes received bytes and queues one job per beat. Depends on rtu_mfe_pkg.

module rtu_mfe_front
  import rtu_mfe_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1),
  localparam int unsigned AW = $clog2(BUFFER_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    cmd_i,
  input  logic [7:0]    rx_data_i,
  input  logic [15:0]   send_len_i,
  input  logic [31:0]   gap_ticks_i,
  input  logic [31:0]   resp_ticks_i,
  input  logic          q_full_i,
  input  logic          fetch_done_i,
  output logic          push_o,
  output job_t          job_o,
  output logic [CW-1:0] job_cnt_o,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [7:0]    wr_data_o
);

  logic [2:0]    mode_q, mode_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   tcnt_q, tcnt_d;
  logic [31:0]   per_q, per_d;
  logic          run_q, run_d;
  logic          pend_q, pend_d;

  logic          accept;
  logic [31:0]   tinc;
  logic [CW-1:0] base, wptr;
  logic [15:0]   clamp_len;
  cmd_e          cmd;

  assign in_ready_o = !q_full_i && !pend_q;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;
  assign cmd        = cmd_e'(cmd_i);

  assign tinc = (tcnt_q < per_q) ? tcnt_q + 32'd1 : tcnt_q;

  // a reply after waiting starts a fresh frame; a full buffer wraps
  assign base      = (mode_q == LS_WAIT) ? '0 : cnt_q;
  assign wptr      = (base == CW'(BUFFER_DEPTH)) ? '0 : base;
  assign wr_addr_o = wptr[AW-1:0];
  assign wr_data_o = rx_data_i;
  assign wr_en_o   = accept && (cmd == CMD_RX_BYTE);

  assign clamp_len = (send_len_i > 16'(BUFFER_DEPTH)) ? 16'(BUFFER_DEPTH) : send_len_i;

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    tcnt_d = tcnt_q;
    per_d  = per_q;
    run_d  = run_q;
    pend_d = pend_q && !fetch_done_i;
    job_o.accepted  = 1'b0;
    job_o.tx_length = '0;
    job_o.fetch     = 1'b0;
    if (accept) begin
      unique case (cmd)
        CMD_TICK: begin
          if (run_q) begin
            if (tinc >= per_q) begin
              run_d  = 1'b0;
              tcnt_d = '0;
              priority if (mode_q == LS_WAIT) begin
                mode_d = LS_TIMEOUT;
              end else if (mode_q == LS_RECEIVING) begin
                mode_d = LS_RECEIVED;
              end else begin
                mode_d = LS_IDLE;
              end
            end else begin
              tcnt_d = tinc;
            end
          end
        end
        CMD_RX_BYTE: begin
          mode_d = LS_RECEIVING;
          cnt_d  = wptr + CW'(1);
          tcnt_d = '0;
          per_d  = gap_ticks_i;
          run_d  = 1'b1;
        end
        CMD_SEND: begin
          if (mode_q == LS_IDLE) begin
            mode_d          = LS_SENDING;
            job_o.accepted  = 1'b1;
            job_o.tx_length = 7'(clamp_len);
          end
        end
        CMD_TX_DONE: begin
          mode_d = LS_WAIT;
          tcnt_d = '0;
          per_d  = resp_ticks_i;
          run_d  = 1'b1;
        end
        CMD_FETCH: begin
          if (cnt_q != '0 && mode_q == LS_RECEIVED) begin
            mode_d         = LS_IDLE;
            job_o.accepted = 1'b1;
            job_o.fetch    = 1'b1;
            pend_d         = 1'b1;
          end
        end
        CMD_RESET: begin
          cnt_d  = '0;
          mode_d = LS_IDLE;
        end
        default: begin
        end
      endcase
    end
    job_o.link_state = mode_d;
  end

  assign job_cnt_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= LS_IDLE;
      cnt_q  <= '0;
      tcnt_q <= '0;
      per_q  <= '0;
      run_q  <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      tcnt_q <= tcnt_d;
      per_q  <= per_d;
      run_q  <= run_d;
      pend_q <= pend_d;
    end
  end

endmodule

@@ hw/rtl/rtu_mfe_queue.sv @@
// Two-entry job queue between front and back parts.
// Depends on rtu_mfe_pkg for defaults only.

module rtu_mfe_queue
  import rtu_mfe_pkg::*;
#(
  parameter int unsigned W = JOB_W
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] slot_q [2];
  logic         wptr_q, wptr_d;
  logic         rptr_q, rptr_d;
  logic [1:0]   fill_q, fill_d;

  assign full_o     = (fill_q == 2'd2);
  assign valid_o    = (fill_q != 2'd0);
  assign pop_data_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    fill_d = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/rtu_mfe_back.sv @@
// Back part: holds the frame buffer, turns jobs into result beats and
// streams a fetched frame one byte per cycle while the output is ready. Depends on rtu_mfe_pkg.

module rtu_mfe_back
  import rtu_mfe_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1),
  localparam int unsigned AW = $clog2(BUFFER_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  job_t          job_i,
  input  logic [CW-1:0] job_cnt_i,
  output logic          pop_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  output logic          fetch_done_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   out_data_o,
  output logic          out_last_o
);

  logic [7:0]    mem [BUFFER_DEPTH];

  logic          stream_q, stream_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0]    sls_q, sls_d;
  logic          rd_vld_q, rd_vld_d;
  logic [7:0]    rd_data_q;
  logic          rd_last_q;
  logic          out_vld_q, out_vld_d;
  logic [31:0]   out_data_q;
  logic          out_last_q;

  logic          out_free, take_rd, issue, take_job, is_last_rd;

  assign out_free   = !out_vld_q || out_ready_i;
  assign take_rd    = rd_vld_q && out_free;
  assign issue      = stream_q && (idx_q != cnt_q) && (!rd_vld_q || take_rd);
  assign take_job   = !stream_q && q_valid_i && (job_i.fetch || out_free);
  assign is_last_rd = (idx_q == cnt_q - CW'(1));

  assign pop_o        = take_job;
  assign fetch_done_o = issue && is_last_rd;

  always_comb begin
    rd_vld_d = issue ? 1'b1 : (take_rd ? 1'b0 : rd_vld_q);
    idx_d    = issue ? idx_q + CW'(1) : idx_q;
    cnt_d    = cnt_q;
    sls_d    = sls_q;
    stream_d = stream_q;
    if (take_job && job_i.fetch) begin
      stream_d = 1'b1;
      idx_d    = '0;
      cnt_d    = job_cnt_i;
      sls_d    = job_i.link_state;
    end else if (stream_q) begin
      stream_d = (idx_d != cnt_q) || rd_vld_d;
    end
    if (take_rd || (take_job && !job_i.fetch)) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_q  <= 1'b0;
      idx_q     <= '0;
      cnt_q     <= '0;
      sls_q     <= LS_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      stream_q  <= stream_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      sls_q     <= sls_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (issue) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
      rd_last_q <= is_last_rd;
    end
  end

  // beat layout: link_state, accepted, tx_length, frame_byte, frame_length
  always_ff @(posedge clk_i) begin
    if (take_rd) begin
      out_data_q <= {6'd0, 7'(cnt_q), rd_data_q, 7'd0, 1'b1, sls_q};
      out_last_q <= rd_last_q;
    end else if (take_job && !job_i.fetch) begin
      out_data_q <= {6'd0, 7'd0, 8'd0, job_i.tx_length, job_i.accepted, job_i.link_state};
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule
